// ----- rtl/core/gtg_pkg.sv -----
package gtg_pkg;

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_SQADD, S_SQRT, S_CHECK, S_CORDIC,
    S_ERR, S_PMUL, S_DIV, S_SPEED, S_SPDOUT, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    ACT_POSE   = 2'd0,
    ACT_GOAL   = 2'd1,
    ACT_CANCEL = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  localparam logic [1:0] REG_ARRIVE  = 2'd0;
  localparam logic [1:0] REG_HEADING = 2'd1;
  localparam logic [1:0] REG_LGAIN   = 2'd2;
  localparam logic [1:0] REG_AGAIN   = 2'd3;

  localparam int CordicSteps = 16;
  localparam int SqrtSteps   = 17;
  localparam int DivSteps    = 32;

  // pi/2 in units of 2^-16 rad
  localparam logic signed [19:0] HALF_PI = 20'sd102944;
  localparam logic signed [17:0] PROG_SCALE = 18'sd25600;

  // arctan(2^-i) in units of 2^-16 rad
  function automatic logic signed [19:0] atan_lut(input logic [3:0] i);
    logic signed [19:0] v;
    case (i)
      4'd0:  v = 20'sd51472;
      4'd1:  v = 20'sd30385;
      4'd2:  v = 20'sd16055;
      4'd3:  v = 20'sd8150;
      4'd4:  v = 20'sd4091;
      4'd5:  v = 20'sd2047;
      4'd6:  v = 20'sd1024;
      4'd7:  v = 20'sd512;
      4'd8:  v = 20'sd256;
      4'd9:  v = 20'sd128;
      4'd10: v = 20'sd64;
      4'd11: v = 20'sd32;
      4'd12: v = 20'sd16;
      4'd13: v = 20'sd8;
      4'd14: v = 20'sd4;
      4'd15: v = 20'sd2;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/go_to_goal_steering_controller.sv -----
// Go-to-goal steering controller. A pose update (tuser 0) stores the pose and, while a goal
// is active, produces one result: distance, progress and either a turn-in-place or a drive
// command, or zero speeds with done set on arrival (the goal is then dropped). A new goal
// (tuser 1) stores the target, and the first goal after reset also latches the initial
// distance; cancel (tuser 2) drops the goal. Items are taken one at a time; s_axis_tready
// is low while one is in work. A steering update runs two squares through the shared 18x18
// multiplier, 17 square-root steps, 16 CORDIC steps, 32 divide steps for progress that are
// skipped when the initial distance is zero, and one gain multiply before the result is
// offered; an arrival is decided right after the square root. The next item is taken in
// the cycle after the result transaction. A first goal keeps the block busy through the
// squares and the square root; other items leave it ready. Registers sit on the APB port
// at 0, 4, 8, 12.
module go_to_goal_steering_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pos_x[15:0], pos_y[31:16], heading[46:32], target_x[62:47], target_y[78:63]
  input  logic [79:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // linear_speed[14:0], turn_rate[30:15], report_x[46:31], report_y[62:47],
  // goal_distance[79:63], progress[95:80]
  output logic [95:0] m_axis_tdata,
  // done_res[0]
  output logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  gtg_pkg::state_e state_q, state_d;

  // configuration
  logic [15:0] arrive_tol_q;
  logic [14:0] head_tol_q;
  logic [11:0] lin_gain_q, ang_gain_q;

  // controller state
  logic signed [15:0] cur_x_q, cur_y_q, goal_x_q, goal_y_q;
  logic signed [14:0] cur_head_q;
  logic               goal_active_q, have_init_q, latch_q;
  logic [16:0]        d0_q, d_q;
  logic signed [15:0] last_prog_q;

  // datapath
  logic signed [35:0] prod_q;
  logic [33:0]        sq_q, n_q, r_q, bit_q;
  logic [4:0]         cnt_q;
  logic signed [27:0] cx_q, cy_q;
  logic signed [19:0] cz_q;
  logic               zero_vec_q;
  logic signed [17:0] err_q;
  logic [31:0]        num_q, quo_q;
  logic [16:0]        rem_q;
  logic               neg_q;

  // output registers
  logic [14:0]        o_lin_q;
  logic signed [15:0] o_turn_q, o_prog_q;
  logic               o_done_q;

  logic wr_en, in_acc;
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == gtg_pkg::S_IDLE);
  assign m_axis_tvalid = (state_q == gtg_pkg::S_OUT);

  // register read
  always_comb begin
    case (paddr[3:2])
      gtg_pkg::REG_ARRIVE:  prdata = {16'd0, arrive_tol_q};
      gtg_pkg::REG_HEADING: prdata = {17'd0, head_tol_q};
      gtg_pkg::REG_LGAIN:   prdata = {20'd0, lin_gain_q};
      gtg_pkg::REG_AGAIN:   prdata = {20'd0, ang_gain_q};
      default:              prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arrive_tol_q <= 16'd13;
      head_tol_q   <= 15'd410;
      lin_gain_q   <= 12'd512;
      ang_gain_q   <= 12'd512;
    end else if (wr_en) begin
      case (paddr[3:2])
        gtg_pkg::REG_ARRIVE:  arrive_tol_q <= pwdata[15:0];
        gtg_pkg::REG_HEADING: head_tol_q   <= pwdata[14:0];
        gtg_pkg::REG_LGAIN:   lin_gain_q   <= pwdata[11:0];
        gtg_pkg::REG_AGAIN:   ang_gain_q   <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // vector to goal
  logic signed [16:0] dx, dy;
  assign dx = 17'({goal_x_q[15], goal_x_q}) - 17'({cur_x_q[15], cur_x_q});
  assign dy = 17'({goal_y_q[15], goal_y_q}) - 17'({cur_y_q[15], cur_y_q});

  // turn decision
  logic [17:0] abs_err;
  logic        turn_mode;
  assign abs_err   = err_q[17] ? 18'(-err_q) : 18'(err_q);
  assign turn_mode = abs_err > {3'd0, head_tol_q};

  // shared multiplier
  logic signed [17:0] mul_a, mul_b;
  always_comb begin
    case (state_q)
      gtg_pkg::S_SQX: begin
        mul_a = {dx[16], dx};
        mul_b = {dx[16], dx};
      end
      gtg_pkg::S_SQY: begin
        mul_a = {dy[16], dy};
        mul_b = {dy[16], dy};
      end
      gtg_pkg::S_ERR: begin
        mul_a = gtg_pkg::PROG_SCALE;
        mul_b = 18'({1'b0, d0_q}) - 18'({1'b0, d_q});
      end
      gtg_pkg::S_SPEED: begin
        if (turn_mode) begin
          mul_a = {6'd0, ang_gain_q};
          mul_b = err_q;
        end else begin
          mul_a = {6'd0, lin_gain_q};
          mul_b = {1'b0, d_q};
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // square root step
  logic [33:0] sq_trial;
  logic        sq_take;
  assign sq_trial = r_q + bit_q;
  assign sq_take  = n_q >= sq_trial;

  // CORDIC step
  logic signed [27:0] xs, ys;
  logic signed [19:0] atan_v, bearing;
  assign xs      = cx_q >>> cnt_q[3:0];
  assign ys      = cy_q >>> cnt_q[3:0];
  assign atan_v  = gtg_pkg::atan_lut(cnt_q[3:0]);
  assign bearing = zero_vec_q ? 20'sd0 : ((cz_q + 20'sd8) >>> 4);

  // divide step
  logic [17:0] rem_sh;
  logic        div_take;
  assign rem_sh   = {rem_q, num_q[31]};
  assign div_take = rem_sh >= {1'b0, d0_q};

  logic signed [32:0] prog_full;
  logic signed [15:0] prog_sat;
  assign prog_full = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  always_comb begin
    if (prog_full > 33'sd32767)       prog_sat = 16'sh7fff;
    else if (prog_full < -33'sd32768) prog_sat = 16'sh8000;
    else                              prog_sat = prog_full[15:0];
  end

  logic signed [35:0] spd_sh;
  assign spd_sh = (prod_q + 36'sd128) >>> 8;

  logic [16:0] d_next;
  assign d_next = sq_take ? 17'((r_q >> 1) + bit_q) : 17'(r_q >> 1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gtg_pkg::S_IDLE: begin
        if (in_acc) begin
          case (gtg_pkg::action_e'(s_axis_tuser))
            gtg_pkg::ACT_POSE: if (goal_active_q) state_d = gtg_pkg::S_SQX;
            gtg_pkg::ACT_GOAL: if (!have_init_q) state_d = gtg_pkg::S_SQX;
            default: ;
          endcase
        end
      end
      gtg_pkg::S_SQX:   state_d = gtg_pkg::S_SQY;
      gtg_pkg::S_SQY:   state_d = gtg_pkg::S_SQADD;
      gtg_pkg::S_SQADD: state_d = gtg_pkg::S_SQRT;
      gtg_pkg::S_SQRT:
        if (cnt_q == 5'(gtg_pkg::SqrtSteps - 1))
          state_d = latch_q ? gtg_pkg::S_IDLE : gtg_pkg::S_CHECK;
      gtg_pkg::S_CHECK:
        state_d = (d_q < {1'b0, arrive_tol_q}) ? gtg_pkg::S_OUT : gtg_pkg::S_CORDIC;
      gtg_pkg::S_CORDIC:
        if (cnt_q == 5'(gtg_pkg::CordicSteps - 1)) state_d = gtg_pkg::S_ERR;
      gtg_pkg::S_ERR:   state_d = gtg_pkg::S_PMUL;
      gtg_pkg::S_PMUL:  state_d = (d0_q == 17'd0) ? gtg_pkg::S_SPEED : gtg_pkg::S_DIV;
      gtg_pkg::S_DIV:
        if (cnt_q == 5'(gtg_pkg::DivSteps - 1)) state_d = gtg_pkg::S_SPEED;
      gtg_pkg::S_SPEED:  state_d = gtg_pkg::S_SPDOUT;
      gtg_pkg::S_SPDOUT: state_d = gtg_pkg::S_OUT;
      gtg_pkg::S_OUT:    if (m_axis_tready) state_d = gtg_pkg::S_IDLE;
      default:           state_d = gtg_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= gtg_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q       <= '0;
      cur_y_q       <= '0;
      cur_head_q    <= '0;
      goal_x_q      <= '0;
      goal_y_q      <= '0;
      goal_active_q <= 1'b0;
      have_init_q   <= 1'b0;
      latch_q       <= 1'b0;
      d0_q          <= '0;
      last_prog_q   <= '0;
      cnt_q         <= '0;
    end else begin
      case (state_q)
        gtg_pkg::S_IDLE: begin
          cnt_q <= '0;
          if (in_acc) begin
            case (gtg_pkg::action_e'(s_axis_tuser))
              gtg_pkg::ACT_POSE: begin
                cur_x_q    <= s_axis_tdata[15:0];
                cur_y_q    <= s_axis_tdata[31:16];
                cur_head_q <= s_axis_tdata[46:32];
                latch_q    <= 1'b0;
              end
              gtg_pkg::ACT_GOAL: begin
                goal_x_q      <= s_axis_tdata[62:47];
                goal_y_q      <= s_axis_tdata[78:63];
                goal_active_q <= 1'b1;
                latch_q       <= 1'b1;
              end
              gtg_pkg::ACT_CANCEL: goal_active_q <= 1'b0;
              default: ;
            endcase
          end
        end
        gtg_pkg::S_SQRT: begin
          if (cnt_q == 5'(gtg_pkg::SqrtSteps - 1)) begin
            cnt_q <= '0;
            if (latch_q) begin
              d0_q        <= d_next;
              have_init_q <= 1'b1;
            end
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        gtg_pkg::S_CHECK:
          if (d_q < {1'b0, arrive_tol_q}) goal_active_q <= 1'b0;
        gtg_pkg::S_CORDIC: cnt_q <= cnt_q + 5'd1;
        gtg_pkg::S_ERR:    cnt_q <= '0;
        gtg_pkg::S_PMUL:   if (d0_q == 17'd0) last_prog_q <= '0;
        gtg_pkg::S_DIV:    cnt_q <= cnt_q + 5'd1;
        // quotient is complete once the divide steps are done
        gtg_pkg::S_SPEED:  if (d0_q != 17'd0) last_prog_q <= prog_sat;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      gtg_pkg::S_SQY:   sq_q <= prod_q[33:0];
      gtg_pkg::S_SQADD: begin
        n_q   <= sq_q + prod_q[33:0];
        r_q   <= '0;
        bit_q <= 34'h1_0000_0000;
      end
      gtg_pkg::S_SQRT: begin
        if (sq_take) begin
          n_q <= n_q - sq_trial;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (cnt_q == 5'(gtg_pkg::SqrtSteps - 1)) d_q <= d_next;
      end
      gtg_pkg::S_CHECK: begin
        zero_vec_q <= (dx == 17'sd0) && (dy == 17'sd0);
        if (dx < 0) begin
          if (dy >= 0) begin
            cx_q <= 28'(dy) <<< 8;
            cy_q <= -(28'(dx) <<< 8);
            cz_q <= gtg_pkg::HALF_PI;
          end else begin
            cx_q <= -(28'(dy) <<< 8);
            cy_q <= 28'(dx) <<< 8;
            cz_q <= -gtg_pkg::HALF_PI;
          end
        end else begin
          cx_q <= 28'(dx) <<< 8;
          cy_q <= 28'(dy) <<< 8;
          cz_q <= '0;
        end
      end
      gtg_pkg::S_CORDIC: begin
        if (cy_q >= 0) begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + atan_v;
        end else begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - atan_v;
        end
      end
      gtg_pkg::S_ERR: err_q <= 18'(bearing) - 18'(cur_head_q);
      gtg_pkg::S_PMUL: begin
        neg_q <= prod_q[35];
        num_q <= prod_q[35] ? 32'(-prod_q) : prod_q[31:0];
        rem_q <= '0;
        quo_q <= '0;
      end
      gtg_pkg::S_DIV: begin
        rem_q <= div_take ? 17'(rem_sh - {1'b0, d0_q}) : rem_sh[16:0];
        quo_q <= {quo_q[30:0], div_take};
        num_q <= {num_q[30:0], 1'b0};
      end
      default: ;
    endcase
  end

  // result registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      gtg_pkg::S_CHECK: begin
        o_lin_q  <= '0;
        o_turn_q <= '0;
        o_prog_q <= last_prog_q;
        o_done_q <= 1'b1;
      end
      gtg_pkg::S_SPDOUT: begin
        o_prog_q <= last_prog_q;
        o_done_q <= 1'b0;
        if (turn_mode) begin
          o_lin_q <= '0;
          if (spd_sh > 36'sd32767)       o_turn_q <= 16'sh7fff;
          else if (spd_sh < -36'sd32768) o_turn_q <= 16'sh8000;
          else                           o_turn_q <= spd_sh[15:0];
        end else begin
          o_turn_q <= '0;
          if (spd_sh > 36'sd32767) o_lin_q <= 15'h7fff;
          else                     o_lin_q <= spd_sh[14:0];
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tdata = {o_prog_q, d_q, cur_y_q, cur_x_q, o_turn_q, o_lin_q};
  assign m_axis_tuser = o_done_q;

  // checks
  a_arrive_drops_goal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> !goal_active_q)
    else $error("goal still active after arrival");
  a_done_zero_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[30:0] == 31'd0))
    else $error("nonzero speed on arrival");
  a_one_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[14:0] == 15'd0 || m_axis_tdata[30:15] == 16'd0))
    else $error("turn and drive at once");
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped before transaction");

endmodule
